[hw/rtl/ebbgc_pkg.sv]
// Package for the element bounding box to grid cells block.
// Holds item and result structs, register index codes and fixed constants.
// No dependencies.
package ebbgc_pkg;

   localparam int NODE_W      = 13;     // node number field width
   localparam int COORD_W     = 32;     // Q16.16 coordinate width
   localparam int CELL_W      = 10;     // grid cell index width
   localparam int GRID        = 1024;   // cells per axis, clamp at GRID-1
   localparam int MAX_NODES_D = 4096;   // default node store depth
   localparam int FIFO_DEPTH  = 8;      // result queue depth, covers pipeline latency
   localparam int KIND_LOAD   = 0;
   localparam int KIND_REF    = 1;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X      = 2'd0,
      CSR_ORIGIN_Y      = 2'd1,
      CSR_ORIGIN_Z      = 2'd2,
      CSR_INV_CELL_SIZE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                      kind;
      logic [NODE_W-1:0]         node_number;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic                      last_node;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_min_x;
      logic [CELL_W-1:0] cell_min_y;
      logic [CELL_W-1:0] cell_min_z;
      logic [CELL_W-1:0] cell_max_x;
      logic [CELL_W-1:0] cell_max_y;
      logic [CELL_W-1:0] cell_max_z;
   } rsp_type;

endpackage

[hw/rtl/element_bounding_box_to_grid_cells.sv]
// Element bounding box to grid cells: node store, running box, cell quantizer.
// Depends on ebbgc_pkg (structs, register codes, constants).
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | req_valid / req_ready | req_type: load or reference
//   rsp     | out       | rsp_valid / rsp_ready | rsp_type: six cell indices
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One item per cycle sustained while req_ready is high. A last reference goes through
// store read, box update, subtract, multiply, round/clamp into the queue.
// req_ready drops only when FIFO_DEPTH results are in flight or queued.
// Synchronous reset clears the box, the start flag and config; the node store is
// not cleared (a node must be loaded before it is referenced).
// csr_ready is always high; config must be written only while idle (the user's duty; not enforced).
module element_bounding_box_to_grid_cells #(
   parameter int MAX_NODES = ebbgc_pkg::MAX_NODES_D
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ebbgc_pkg::req_type            req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ebbgc_pkg::rsp_type            rsp,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  ebbgc_pkg::csr_index_type      csr_index,
   input  logic [ebbgc_pkg::COORD_W-1:0] csr_data
);
   import ebbgc_pkg::*;

   localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int IW   = (AW > NODE_W) ? AW : NODE_W;
   localparam int PW   = $clog2(FIFO_DEPTH);
   localparam int CW   = $clog2(FIFO_DEPTH + 1);
   localparam int MW   = 3 * COORD_W;
   localparam int PRW  = 2 * COORD_W;

   // ---------------- config registers ----------------
   logic signed [COORD_W-1:0] org_ff [3];
   logic [COORD_W-1:0]        inv_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         inv_ff    <= COORD_W'(65536);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X:      org_ff[0] <= csr_data;
            CSR_ORIGIN_Y:      org_ff[1] <= csr_data;
            CSR_ORIGIN_Z:      org_ff[2] <= csr_data;
            CSR_INV_CELL_SIZE: inv_ff    <= csr_data;
            default:           inv_ff    <= inv_ff;
         endcase
      end
   end

   // ---------------- accept and node store ----------------
   logic          req_acc;
   logic          res_acc;     // accepted item that will produce a result
   logic [IW-1:0] num_wide;
   logic [IW-1:0] num_m1;
   logic [AW-1:0] addr;
   logic          node_ok;

   assign req_acc  = req_valid && req_ready;
   assign res_acc  = req_acc && (req.kind == 1'(KIND_REF)) && req.last_node;
   assign num_wide = IW'(req.node_number);
   assign num_m1   = num_wide - IW'(1);
   assign addr     = AW'(num_m1);
   // one-based numbers 1..MAX_NODES are in range
   assign node_ok  = (req.node_number != '0) && (32'(req.node_number) <= 32'(MAX_NODES));

   logic [MW-1:0] mem [MAX_NODES];
   logic [MW-1:0] rd_ff;

   // Load writes at its accept edge; a reference reads at its own accept edge,
   // so a reference right behind a load of the same node sees the new data.
   always_ff @(posedge clock) begin
      if (req_acc && (req.kind == 1'(KIND_LOAD)) && node_ok) begin
         mem[addr] <= {req.pos_x, req.pos_y, req.pos_z};
      end
      if (req_acc) begin
         rd_ff <= mem[addr];
      end
   end

   // ---------------- stage 1: running box ----------------
   logic s1_vld_ff, s1_last_ff, s1_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_acc && (req.kind == 1'(KIND_REF));
      end
      s1_last_ff <= req.last_node;
      s1_ok_ff   <= node_ok;
   end

   logic signed [COORD_W-1:0] run_min_ff [3];
   logic signed [COORD_W-1:0] run_max_ff [3];
   logic signed [COORD_W-1:0] min_in [3];
   logic signed [COORD_W-1:0] max_in [3];
   logic signed [COORD_W-1:0] pt [3];
   logic                      start_ff;

   // out-of-range node reads as the origin point (0,0,0)
   assign pt[0] = s1_ok_ff ? rd_ff[3*COORD_W-1:2*COORD_W] : '0;
   assign pt[1] = s1_ok_ff ? rd_ff[2*COORD_W-1:COORD_W]   : '0;
   assign pt[2] = s1_ok_ff ? rd_ff[COORD_W-1:0]           : '0;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (start_ff) begin
            min_in[k] = pt[k];
            max_in[k] = pt[k];
         end else begin
            min_in[k] = (pt[k] < run_min_ff[k]) ? pt[k] : run_min_ff[k];
            max_in[k] = (pt[k] > run_max_ff[k]) ? pt[k] : run_max_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         for (int k = 0; k < 3; k++) begin
            run_min_ff[k] <= '0;
            run_max_ff[k] <= '0;
         end
      end else if (s1_vld_ff) begin
         start_ff <= s1_last_ff;
         for (int k = 0; k < 3; k++) begin
            run_min_ff[k] <= min_in[k];
            run_max_ff[k] <= max_in[k];
         end
      end
   end

   // ---------------- stage 2: box capture ----------------
   // lanes 0..2 are minimum x,y,z; lanes 3..5 maximum x,y,z
   logic                      s2_vld_ff;
   logic signed [COORD_W-1:0] box_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff && s1_last_ff;
      end
      for (int k = 0; k < 3; k++) begin
         box_ff[k]     <= min_in[k];
         box_ff[k + 3] <= max_in[k];
      end
   end

   // ---------------- stage 3: offset from origin ----------------
   logic                 s3_vld_ff;
   logic [COORD_W-1:0]   mag_ff [6];
   logic signed [COORD_W:0] diff [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         diff[k] = $signed({box_ff[k][COORD_W-1], box_ff[k]})
                 - $signed({org_ff[k % 3][COORD_W-1], org_ff[k % 3]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      // zero or negative offset maps to cell 0: force the magnitude to zero
      for (int k = 0; k < 6; k++) begin
         mag_ff[k] <= diff[k][COORD_W] ? '0 : diff[k][COORD_W-1:0];
      end
   end

   // ---------------- stage 4: scale ----------------
   logic           s4_vld_ff;
   logic [PRW-1:0] prod_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      for (int k = 0; k < 6; k++) begin
         prod_ff[k] <= PRW'(mag_ff[k]) * PRW'(inv_ff);
      end
   end

   // ---------------- stage 5: round, clamp, enqueue ----------------
   logic [PRW:0]      rnd  [6];
   logic [COORD_W:0]  whole [6];
   logic [CELL_W-1:0] cell_idx [6];
   rsp_type           res_in;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         // add one half in Q32.32, keep the integer part
         rnd[k]      = {1'b0, prod_ff[k]} + (PRW + 1)'(64'h8000_0000);
         whole[k]    = rnd[k][PRW:COORD_W];
         cell_idx[k] = (whole[k] > (COORD_W + 1)'(GRID - 1)) ? CELL_W'(GRID - 1)
                                                            : CELL_W'(whole[k]);
      end
      res_in.cell_min_x = cell_idx[0];
      res_in.cell_min_y = cell_idx[1];
      res_in.cell_min_z = cell_idx[2];
      res_in.cell_max_x = cell_idx[3];
      res_in.cell_max_y = cell_idx[4];
      res_in.cell_max_z = cell_idx[5];
   end

   rsp_type       fifo_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] fill_ff;     // queued results
   logic [CW-1:0] credit_ff;   // results accepted but not yet delivered
   logic          pop;

   assign rsp_valid = (fill_ff != '0);
   assign rsp       = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (credit_ff < CW'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (s4_vld_ff) begin
         fifo_ff[wr_ptr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (s4_vld_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         fill_ff   <= fill_ff + CW'(s4_vld_ff) - CW'(pop);
         credit_ff <= credit_ff + CW'(res_acc) - CW'(pop);
      end
   end

   // ---------------- checks ----------------
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CW'(FIFO_DEPTH))
      else $error("result credit count exceeds queue depth");

   a_fill_le_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("queued results exceed outstanding results");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (fill_ff < CW'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   a_last_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      res_acc |=> s1_vld_ff && s1_last_ff)
      else $error("last reference lost before box update");

   a_s1_ref_only: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req.kind == 1'(KIND_LOAD)) |=> !s1_vld_ff)
      else $error("load entered the box update stage");

endmodule
